/* design/ordered_list_engine_top_defines.svh */
// Assertion macros shared by the ordered list engine design files.
`ifndef ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_LIST_ENGINE_TOP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define OLE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition that must hold in the same cycle as its trigger.
`define OLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ole_pkg.sv */
// Constants, codes and address helpers for the ordered list engine.
package ole_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int VAL_W    = 32;

  localparam logic [VAL_W-1:0] EMPTY_MARK = '1;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_REM_VALUE = 3'd2,
    ACT_REM_FRONT = 3'd3,
    ACT_FIND      = 3'd4,
    ACT_CLEAR     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Physical slot of the entry that lies off places behind the head.
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                input logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Slot just in front of the head, wrapping round the ring.
  function automatic logic [ADDR_W-1:0] slot_before(input logic [ADDR_W-1:0] head);
    logic [ADDR_W-1:0] res;
    if (head == '0) begin
      res = ADDR_W'(CAPACITY - 1);
    end else begin
      res = head - ADDR_W'(1);
    end
    return res;
  endfunction

endpackage

/* design/ole_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ordered_list_engine_top.sv */
// Ordered list engine: a ring of entries in one RAM with head pointer and count.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  input     | in_valid / in_ready  | action, value
//  output    | out_valid / out_ready| status, found, position, removed_value,
//            |                      | entry_count, head_value, tail_value
//
// Inserts, unknown actions and remove front fetch the head and tail through the single
// RAM read port after each update. When the list ends up empty both fetches are
// skipped, as for clear and for find and remove by value on an empty list. Otherwise
// find scans the list and remove by value scans it and then moves later entries one
// place forward, at one entry a cycle.
// Reset clears the count and head pointer at once; the RAM itself is not cleared.
// A new item is taken while the previous result waits; a stalled output holds the
// engine in its final state until the result register frees up.
module ordered_list_engine_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  action,
  input  logic signed [31:0]          value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic                        found,
  output logic [3:0]                  position,
  output logic signed [31:0]          removed_value,
  output logic [4:0]                  entry_count,
  output logic signed [31:0]          head_value,
  output logic signed [31:0]          tail_value
);

  import ole_pkg::*;

`include "ordered_list_engine_top_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_POP,
    S_HEAD,
    S_TAIL,
    S_FIN,
    S_DONE
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  cnt;
  action_t           act;
  logic [VAL_W-1:0]  val;

  status_t           res_status;
  logic              res_found;
  logic [3:0]        res_pos;
  logic [VAL_W-1:0]  res_removed;
  logic [VAL_W-1:0]  res_head;
  logic [VAL_W-1:0]  res_tail;

  logic [CNT_W-1:0]  rd_idx;
  logic              cmp_valid;
  logic [CNT_W-1:0]  cmp_idx;
  logic              wr_pend;
  logic [CNT_W-1:0]  wr_idx;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  logic              accept;
  logic              full;
  logic              match;
  logic              last_cmp;
  logic              rd_more;
  logic [31:0]       cmp_idx_wide;
  logic [3:0]        pos_sat;
  logic [31:0]       cnt_wide;
  logic [4:0]        cnt_sat;

  ole_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (cnt == CNT_W'(CAPACITY));
  assign match    = cmp_valid && (ram_rdata == val);
  assign last_cmp = (cmp_idx == cnt - CNT_W'(1));
  assign rd_more  = (rd_idx < cnt);

  // Positions and counts beyond the field width saturate.
  assign cmp_idx_wide = 32'(cmp_idx);
  assign pos_sat      = (cmp_idx_wide > 32'd15) ? 4'd15 : cmp_idx_wide[3:0];
  assign cnt_wide     = 32'(cnt);
  assign cnt_sat      = (cnt_wide > 32'd31) ? 5'd31 : cnt_wide[4:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head;
    ram_wdata = value;
    ram_raddr = head;
    case (state)
      S_IDLE: begin
        if (accept && !full) begin
          if (action_t'(action) == ACT_INS_FRONT) begin
            ram_we    = 1'b1;
            ram_waddr = slot_before(head);
          end else if (action_t'(action) == ACT_INS_BACK) begin
            ram_we    = 1'b1;
            ram_waddr = slot_of(head, cnt);
          end
        end
      end
      S_SCAN: begin
        ram_raddr = slot_of(head, rd_idx);
      end
      S_SHIFT: begin
        // Each entry behind the removed one moves one place forward.
        ram_raddr = slot_of(head, rd_idx);
        ram_we    = wr_pend;
        ram_waddr = slot_of(head, wr_idx);
        ram_wdata = ram_rdata;
      end
      S_TAIL: begin
        ram_raddr = slot_of(head, cnt - CNT_W'(1));
      end
      default: begin
        ram_raddr = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      cnt       <= '0;
      cmp_valid <= 1'b0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The done state reloads the result register itself.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            act         <= action_t'(action);
            val         <= value;
            res_found   <= 1'b0;
            res_pos     <= '0;
            res_removed <= '0;
            rd_idx      <= '0;
            cmp_valid   <= 1'b0;
            case (action_t'(action))
              ACT_INS_FRONT: begin
                state <= S_HEAD;
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_OK;
                  head       <= slot_before(head);
                  cnt        <= cnt + CNT_W'(1);
                end
              end
              ACT_INS_BACK: begin
                state <= S_HEAD;
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_OK;
                  cnt        <= cnt + CNT_W'(1);
                end
              end
              ACT_REM_VALUE, ACT_FIND: begin
                if (cnt == '0) begin
                  res_status <= ST_NOT_FOUND;
                  state      <= S_HEAD;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_SCAN;
                end
              end
              ACT_REM_FRONT: begin
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_HEAD;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_POP;
                end
              end
              ACT_CLEAR: begin
                res_status <= ST_OK;
                cnt        <= '0;
                state      <= S_HEAD;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_HEAD;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Reads are issued in the cycle before their compare.
          if (match) begin
            cmp_valid <= 1'b0;
            if (act == ACT_FIND) begin
              res_found <= 1'b1;
              res_pos   <= pos_sat;
              state     <= S_HEAD;
            end else begin
              rd_idx  <= cmp_idx + CNT_W'(1);
              wr_pend <= 1'b0;
              state   <= S_SHIFT;
            end
          end else if (cmp_valid && last_cmp) begin
            cmp_valid  <= 1'b0;
            res_status <= ST_NOT_FOUND;
            state      <= S_HEAD;
          end else begin
            if (rd_more) begin
              rd_idx <= rd_idx + CNT_W'(1);
            end
            cmp_valid <= rd_more;
            cmp_idx   <= rd_idx;
          end
        end
        S_SHIFT: begin
          if (rd_more) begin
            rd_idx  <= rd_idx + CNT_W'(1);
            wr_pend <= 1'b1;
            wr_idx  <= rd_idx - CNT_W'(1);
          end else begin
            wr_pend <= 1'b0;
            if (!wr_pend) begin
              cnt   <= cnt - CNT_W'(1);
              state <= S_HEAD;
            end
          end
        end
        S_POP: begin
          res_removed <= ram_rdata;
          head        <= slot_of(head, CNT_W'(1));
          cnt         <= cnt - CNT_W'(1);
          state       <= S_HEAD;
        end
        S_HEAD: begin
          if (cnt == '0) begin
            res_head <= EMPTY_MARK;
            res_tail <= EMPTY_MARK;
            state    <= S_DONE;
          end else begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          res_head <= ram_rdata;
          state    <= S_FIN;
        end
        S_FIN: begin
          res_tail <= ram_rdata;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            found         <= res_found;
            position      <= res_pos;
            removed_value <= res_removed;
            entry_count   <= cnt_sat;
            head_value    <= res_head;
            tail_value    <= res_tail;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `OLE_ASSERT_ALWAYS(a_cnt_bound, (32'(cnt) <= CAPACITY), "entry count above capacity")
  `OLE_ASSERT_IMPL(a_write_states, ram_we, (state == S_IDLE || state == S_SHIFT), "RAM written outside insert or shift")
  `OLE_ASSERT_NEXT(a_ins_back_grows, accept && (action_t'(action) == ACT_INS_BACK) && !full, (cnt == $past(cnt) + CNT_W'(1)), "insert at back did not grow the list")
  `OLE_ASSERT_IMPL(a_shift_in_range, (state == S_SHIFT), (rd_idx <= cnt), "shift read index beyond the list")
  `OLE_ASSERT_IMPL(a_found_ok, out_valid && found, (status == ST_OK), "found reported without ok status")

endmodule
